// ===== hw/rtl/signed_permutation_direction_match_top_defines.svh =====
// Assertion macros for the signed permutation direction match block
`ifndef SIGNED_PERMUTATION_DIRECTION_MATCH_TOP_DEFINES_SVH
`define SIGNED_PERMUTATION_DIRECTION_MATCH_TOP_DEFINES_SVH

// same-cycle implication, switched off while rst_n is low
`define SPDM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, switched off while rst_n is low
`define SPDM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/spdm_pkg.sv =====
// Types, constants and candidate table builder for the direction match block
package spdm_pkg;

  localparam int CELL_N = 48;   // signed 3x3 permutations
  localparam int COMP_W = 32;
  localparam int TERM_W = 64;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef comp_t [2:0] vec3_t;
  typedef logic [TERM_W-1:0] term_t;
  // [target axis][source axis][source negated]
  typedef term_t [2:0][2:0][1:0] term_arr_t;

  // signed permutation: row i at [3i+2:3i] = {negate, source column}
  typedef logic [8:0] sperm_t;

  typedef struct packed {
    logic   vld;
    sperm_t sp;
  } cand_t;

  typedef cand_t [CELL_N-1:0] cand_tab_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic   vld;
    logic   found;
    sperm_t best;
  } tok_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TERMS,
    ST_SCAN,
    ST_HOLD
  } spdm_state_t;

  localparam logic [1:0] DIM_2D = 2'd2;
  localparam logic [1:0] DIM_3D = 2'd3;

  localparam sperm_t SP_ID = 9'b010_001_000;
  localparam sperm_t SP_QX = 9'b001_110_000;
  localparam sperm_t SP_QY = 9'b000_001_110;
  localparam sperm_t SP_QZ = 9'b010_000_101;

  // product a * b of two signed permutations
  function automatic sperm_t sp_mul(input sperm_t a, input sperm_t b);
    sperm_t r;
    int     pa;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      pa = int'(a[3*i +: 2]);
      r[3*i +: 2] = b[3*pa +: 2];
      r[3*i+2]    = a[3*i+2] ^ b[3*pa+2];
    end
    return r;
  endfunction

  function automatic sperm_t sp_pow(input sperm_t g, input int n);
    sperm_t r;
    r = SP_ID;
    for (int k = 0; k < 3; k++) begin
      if (k < n) r = sp_mul(r, g);
    end
    return r;
  endfunction

  // rotation list: identity, then x, y, z by one to three quarter turns (2D: z only)
  function automatic sperm_t rot_of(input logic is3d, input int a);
    sperm_t r;
    r = SP_ID;
    if (!is3d) begin
      r = sp_pow(SP_QZ, a);
    end else begin
      case (a)
        1: r = sp_pow(SP_QX, 1);
        2: r = sp_pow(SP_QX, 2);
        3: r = sp_pow(SP_QX, 3);
        4: r = sp_pow(SP_QY, 1);
        5: r = sp_pow(SP_QY, 2);
        6: r = sp_pow(SP_QY, 3);
        7: r = sp_pow(SP_QZ, 1);
        8: r = sp_pow(SP_QZ, 2);
        9: r = sp_pow(SP_QZ, 3);
        default: r = SP_ID;
      endcase
    end
    return r;
  endfunction

  // axis reflections, negate bits {z, y, x}
  function automatic sperm_t refl_of(input logic is3d, input int b);
    sperm_t     r;
    logic [2:0] neg;
    neg = 3'b000;
    if (!is3d) begin
      neg = 3'(b);
    end else begin
      case (b)
        1: neg = 3'b001;
        2: neg = 3'b010;
        3: neg = 3'b100;
        4: neg = 3'b011;
        5: neg = 3'b110;
        6: neg = 3'b101;
        7: neg = 3'b111;
        default: neg = 3'b000;
      endcase
    end
    r    = SP_ID;
    r[2] = neg[0];
    r[5] = neg[1];
    r[8] = neg[2];
    return r;
  endfunction

  // distinct products R1*F*R2 in order of first appearance in the search
  function automatic cand_tab_t build_cands(input logic is3d);
    cand_tab_t tab;
    int        cnt;
    int        nrot;
    int        nref;
    sperm_t    left;
    sperm_t    m;
    logic      dup;
    tab  = '0;
    cnt  = 0;
    nrot = is3d ? 10 : 4;
    nref = is3d ? 8 : 4;
    for (int a = 0; a < nrot; a++) begin
      for (int b = 0; b < nref; b++) begin
        left = sp_mul(rot_of(is3d, a), refl_of(is3d, b));
        for (int c = 0; c < nrot; c++) begin
          m   = sp_mul(left, rot_of(is3d, c));
          dup = 1'b0;
          for (int k = 0; k < cnt; k++) begin
            if (tab[k].sp == m) dup = 1'b1;
          end
          if (!dup && cnt < CELL_N) begin
            tab[cnt].vld = 1'b1;
            tab[cnt].sp  = m;
            cnt++;
          end
        end
      end
    end
    return tab;
  endfunction

endpackage

// ===== hw/rtl/signed_permutation_direction_match_top.sv =====
// Signed permutation direction match: top level with config, control and cell chain
//
// Input stream: one request per source/target vector pair, six Q8.24 components.
// Output stream: found flag in tuser and the matching signed permutation matrix
// in tdata, or found = 0 with a zero matrix when nothing is close enough.
// Configuration: APB port, dimension at address 0, match_tolerance at address 8;
// write only while the block is idle.
// A request first passes the squared-difference unit (18 terms through one 32x32
// multiplier, one per cycle, plus a register stage), then its search token runs
// down the chain of 48 candidate cells, one cell per cycle, then the result
// register captures the result and the output register presents it. One request
// is in flight at a time: the next one is taken once the last result has moved
// to the output register.
// Reset: dimension 3, tolerance 281, output empty, ready for a request.
// A stalled receiver holds the finished result in the output register; the
// next request is still taken and its result waits until that register frees.
`include "signed_permutation_direction_match_top_defines.svh"

module signed_permutation_direction_match_top (
  input  logic         clk,
  input  logic         rst_n,
  // input request
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [191:0] in_tdata,   // source_x, source_y, source_z, target_x, target_y, target_z
  // result
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [23:0]  out_tdata,  // m00, m01, m02, m10, m11, m12, m20, m21, m22, zero fill
  output logic         out_tuser,  // found
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);
  import spdm_pkg::*;

  localparam logic REG_DIMENSION = 1'b0;
  localparam logic REG_TOLERANCE = 1'b1;
  localparam int   MAT_W         = 18;

  localparam cand_tab_t CANDS3 = build_cands(1'b1);
  localparam cand_tab_t CANDS2 = build_cands(1'b0);

  spdm_state_t state_r;
  spdm_state_t state_nxt;

  logic [1:0]  dim_r;
  term_t       tol_r;
  logic        cfg_wr;
  logic        is3d;
  logic        is2d;

  vec3_t       src;
  vec3_t       tgt;
  term_arr_t   terms;
  logic        term_done;
  logic        in_acc;
  logic        res_load;
  logic        out_load;

  tok_t [CELL_N:0]  chain;
  logic [CELL_N:0]  chain_vld;
  tok_t             tail;

  logic [MAT_W-1:0] mat_nxt;
  logic [MAT_W-1:0] res_mat_r;
  logic             res_found_r;
  logic             out_tvalid_r;
  logic [MAT_W-1:0] out_mat_r;
  logic             out_found_r;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= DIM_3D;
      tol_r <= 64'd281;
    end else if (cfg_wr) begin
      if (paddr[3] == REG_DIMENSION) dim_r <= pwdata[1:0];
      if (paddr[3] == REG_TOLERANCE) tol_r <= pwdata;
    end
  end

  assign prdata = (paddr[3] == REG_TOLERANCE) ? tol_r : {62'd0, dim_r};

  assign is3d = (dim_r == DIM_3D);
  assign is2d = (dim_r == DIM_2D);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    res_load  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = ST_TERMS;
      end
      ST_TERMS: begin
        if (term_done) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (tail.vld) begin
          res_load  = 1'b1;
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_acc = in_tvalid && in_tready;

  assign src[0] = in_tdata[31:0];
  assign src[1] = in_tdata[63:32];
  assign src[2] = in_tdata[95:64];
  assign tgt[0] = in_tdata[127:96];
  assign tgt[1] = in_tdata[159:128];
  assign tgt[2] = in_tdata[191:160];

  spdm_terms u_terms (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .src   (src),
    .tgt   (tgt),
    .terms (terms),
    .done  (term_done)
  );

  // token enters once all terms are in place
  assign chain[0].vld   = term_done;
  assign chain[0].found = 1'b0;
  assign chain[0].best  = '0;

  for (genvar k = 0; k < CELL_N; k++) begin : g_cell
    cand_t cand;
    assign cand = is3d ? CANDS3[k] : (is2d ? CANDS2[k] : '0);

    spdm_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .terms   (terms),
      .tol     (tol_r),
      .use_z   (is3d),
      .cand    (cand),
      .tok_in  (chain[k]),
      .tok_out (chain[k+1])
    );
  end

  for (genvar k = 0; k <= CELL_N; k++) begin : g_vld
    assign chain_vld[k] = chain[k].vld;
  end

  assign tail = chain[CELL_N];

  // matrix entries from the winning permutation; 2D keeps the upper-left 2x2
  always_comb begin
    mat_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (tail.found && (is3d || (i < 2 && j < 2)) && (tail.best[3*i +: 2] == 2'(j))) begin
          mat_nxt[2*(3*i+j) +: 2] = tail.best[3*i+2] ? 2'b11 : 2'b01;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_mat_r   <= mat_nxt;
      res_found_r <= tail.found;
    end
    if (out_load) begin
      out_mat_r   <= res_mat_r;
      out_found_r <= res_found_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'd0, out_mat_r};
  assign out_tuser  = out_found_r;

  `SPDM_ASSERT_NOW(a_single_token, 1'b1, $countones(chain_vld) <= 1, "more than one token in the cell chain")
  `SPDM_ASSERT_NOW(a_tail_in_scan, tail.vld, state_r == ST_SCAN, "token left the chain outside the scan")
  `SPDM_ASSERT_NEXT(a_terms_to_scan, term_done, state_r == ST_SCAN, "term unit finished but no scan started")
  `SPDM_ASSERT_NOW(a_found_nonzero, out_tvalid_r && out_found_r, out_mat_r != '0, "match reported with zero matrix")

endmodule

// ===== hw/rtl/spdm_terms.sv =====
// Squared difference unit: all eighteen (+/-source - target)^2 terms, one a cycle
module spdm_terms (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  spdm_pkg::vec3_t   src,
  input  spdm_pkg::vec3_t   tgt,
  output spdm_pkg::term_arr_t terms,
  output logic              done
);
  import spdm_pkg::*;

  localparam logic [1:0] AX_LAST = 2'd2;

  vec3_t       src_r;
  vec3_t       tgt_r;
  logic        busy_r;
  logic [1:0]  ax_t_r;
  logic [1:0]  ax_s_r;
  logic        neg_r;
  logic        last_step;

  logic signed [COMP_W:0] s_ext;
  logic signed [COMP_W:0] t_ext;
  logic signed [COMP_W:0] diff;
  logic [COMP_W:0]        mag_nxt;

  logic [COMP_W:0] mag_r;
  logic            s1_vld_r;
  logic            s1_last_r;
  logic [1:0]      s1_t_r;
  logic [1:0]      s1_s_r;
  logic            s1_neg_r;
  term_t           sq;
  term_arr_t       terms_r;
  logic            done_r;

  assign last_step = (ax_t_r == AX_LAST) && (ax_s_r == AX_LAST) && neg_r;

  always_comb begin
    s_ext   = {src_r[ax_s_r][COMP_W-1], src_r[ax_s_r]};
    t_ext   = {tgt_r[ax_t_r][COMP_W-1], tgt_r[ax_t_r]};
    // a negated source gives -(s + t)
    diff    = neg_r ? (s_ext + t_ext) : (s_ext - t_ext);
    mag_nxt = diff[COMP_W] ? (~diff + 1'b1) : diff;
  end

  // magnitude of 2^32 or more saturates the square
  assign sq = mag_r[COMP_W] ? '1 :
              ({{COMP_W{1'b0}}, mag_r[COMP_W-1:0]} * {{COMP_W{1'b0}}, mag_r[COMP_W-1:0]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      ax_t_r    <= '0;
      ax_s_r    <= '0;
      neg_r     <= 1'b0;
      s1_vld_r  <= 1'b0;
      s1_last_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      s1_vld_r  <= busy_r;
      s1_last_r <= busy_r && last_step;
      done_r    <= s1_vld_r && s1_last_r;
      if (start) begin
        busy_r <= 1'b1;
        ax_t_r <= '0;
        ax_s_r <= '0;
        neg_r  <= 1'b0;
      end else if (busy_r) begin
        neg_r <= ~neg_r;
        if (neg_r) begin
          if (ax_s_r == AX_LAST) begin
            ax_s_r <= '0;
            ax_t_r <= ax_t_r + 2'd1;
          end else begin
            ax_s_r <= ax_s_r + 2'd1;
          end
        end
        if (last_step) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      src_r <= src;
      tgt_r <= tgt;
    end
    mag_r    <= mag_nxt;
    s1_t_r   <= ax_t_r;
    s1_s_r   <= ax_s_r;
    s1_neg_r <= neg_r;
    if (s1_vld_r) terms_r[s1_t_r][s1_s_r][s1_neg_r] <= sq;
  end

  assign terms = terms_r;
  assign done  = done_r;

endmodule

// ===== hw/rtl/spdm_cell.sv =====
// One candidate cell: tests its signed permutation and passes the search token on
module spdm_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  spdm_pkg::term_arr_t terms,
  input  spdm_pkg::term_t     tol,
  input  logic                use_z,
  input  spdm_pkg::cand_t     cand,
  input  spdm_pkg::tok_t      tok_in,
  output spdm_pkg::tok_t      tok_out
);
  import spdm_pkg::*;

  term_t             row_term [3];
  logic [TERM_W+1:0] dist_sum;
  logic              match;
  tok_t              tok_nxt;
  tok_t              tok_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      row_term[i] = terms[i][cand.sp[3*i +: 2]][cand.sp[3*i+2]];
    end
    // exact sum: anything at or over 2^64 fails the compare like the saturated value
    dist_sum = {2'b00, row_term[0]} + {2'b00, row_term[1]} +
               (use_z ? {2'b00, row_term[2]} : '0);
    match    = cand.vld && (dist_sum < {2'b00, tol});

    tok_nxt.vld   = tok_in.vld;
    tok_nxt.found = tok_in.found || match;
    tok_nxt.best  = tok_in.found ? tok_in.best : cand.sp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== tb/tb_spdm_match_checker.sv =====
`timescale 1ns / 100ps
// Checker for the direction match block: watches both streams and the APB port, predicts and compares
module tb_spdm_match_checker #(
  parameter logic [3:0] DIM_ADDR = 4'h0,
  parameter logic [3:0] TOL_ADDR = 4'h8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [191:0] in_tdata,   // source_x, source_y, source_z, target_x, target_y, target_z
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [23:0]  out_tdata,  // m00, m01, m02, m10, m11, m12, m20, m21, m22, zero fill
  input  logic         out_tuser,  // found
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  input  logic         pready,
  output int           n_mismatch,
  output int           n_pending
);
  import spdm_pkg::*;

  localparam logic [63:0] RESET_TOL  = 64'd281;
  localparam logic [1:0]  POS1       = 2'b01;
  localparam logic [1:0]  NEG1       = 2'b11;

  // row-major 3x3, entry 3*row+col, each 2-bit signed
  typedef logic [8:0][1:0] mat_t;

  typedef struct packed {
    logic found;
    mat_t m;
  } match_t;

  mat_t   search_2d[$];
  mat_t   search_3d[$];
  match_t awaited_matches[$];
  logic [1:0]  dim_reg;
  logic [63:0] tol_reg;
  int          mismatch_total = 0;

  function automatic int ent(logic [1:0] e);
    return int'($signed(e));
  endfunction

  function automatic mat_t mat_mul(mat_t a, mat_t b);
    mat_t r;
    int   acc;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += ent(a[3*i+k]) * ent(b[3*k+j]);
        r[3*i+j] = 2'(acc);
      end
    end
    return r;
  endfunction

  // diagonal sign matrix, mask bits {z, y, x} set where the axis is flipped
  function automatic mat_t diag_signs(logic [2:0] mask);
    mat_t r;
    r = '0;
    r[0] = mask[0] ? NEG1 : POS1;
    r[4] = mask[1] ? NEG1 : POS1;
    r[8] = mask[2] ? NEG1 : POS1;
    return r;
  endfunction

  function automatic mat_t quarter_turn(int ax);
    mat_t r;
    r = '0;
    case (ax)
      0: begin
        r[0] = POS1; r[5] = NEG1; r[7] = POS1;
      end
      1: begin
        r[2] = NEG1; r[4] = POS1; r[6] = POS1;
      end
      default: begin
        r[1] = NEG1; r[3] = POS1; r[8] = POS1;
      end
    endcase
    return r;
  endfunction

  function automatic mat_t mat_pow(mat_t g, int n);
    mat_t r;
    r = diag_signs(3'b000);
    repeat (n) r = mat_mul(r, g);
    return r;
  endfunction

  function automatic mat_t rotation_at(bit is3d, int idx);
    if (!is3d) return mat_pow(quarter_turn(2), idx);
    if (idx == 0) return diag_signs(3'b000);
    return mat_pow(quarter_turn((idx - 1) / 3), (idx - 1) % 3 + 1);
  endfunction

  // identity, x, y, z, xy, yz, zx, xyz
  function automatic logic [2:0] flip_mask_3d(int b);
    case (b)
      1: return 3'b001;
      2: return 3'b010;
      3: return 3'b100;
      4: return 3'b011;
      5: return 3'b110;
      6: return 3'b101;
      7: return 3'b111;
      default: return 3'b000;
    endcase
  endfunction

  // products R1*F*R2 in search order, repeats dropped: first hit is unchanged
  initial begin : build_search_order
    mat_t rots[$];
    mat_t flips[$];
    mat_t order[$];
    mat_t prod;
    bit   known;
    for (int d = 0; d < 2; d++) begin
      rots.delete();
      flips.delete();
      order.delete();
      for (int a = 0; a < (d ? 10 : 4); a++) rots = {rots, rotation_at(d == 1, a)};
      for (int b = 0; b < (d ? 8 : 4); b++)
        flips = {flips, diag_signs(d ? flip_mask_3d(b) : 3'(b))};
      foreach (rots[a]) begin
        foreach (flips[b]) begin
          foreach (rots[c]) begin
            prod  = mat_mul(mat_mul(rots[a], flips[b]), rots[c]);
            known = 1'b0;
            foreach (order[k]) if (order[k] == prod) known = 1'b1;
            if (!known) order = {order, prod};
          end
        end
      end
      if (d == 1) search_3d = order;
      else search_2d = order;
    end
  end

  function automatic match_t predict_match(logic [191:0] req, logic [1:0] dim,
                                           logic [63:0] tol);
    match_t      res;
    longint      src[3];
    longint      tgt[3];
    longint      img;
    longint      diff;
    int          n;
    int          n_cand;
    mat_t        m;
    logic [63:0] mag;
    logic [63:0] term;
    logic [63:0] sq_sum;
    logic [64:0] acc;
    res = '0;
    for (int i = 0; i < 3; i++) begin
      src[i] = longint'($signed(req[32*i +: 32]));
      tgt[i] = longint'($signed(req[96+32*i +: 32]));
    end
    n      = (dim == DIM_3D) ? 3 : (dim == DIM_2D) ? 2 : 0;
    n_cand = (n == 3) ? search_3d.size() : (n == 2) ? search_2d.size() : 0;
    for (int c = 0; c < n_cand && !res.found; c++) begin
      m      = (n == 3) ? search_3d[c] : search_2d[c];
      sq_sum = '0;
      for (int i = 0; i < n; i++) begin
        img = 0;
        for (int j = 0; j < n; j++) img += longint'(ent(m[3*i+j])) * src[j];
        diff   = img - tgt[i];
        mag    = (diff < 0) ? 64'(-diff) : 64'(diff);
        term   = (mag >= 64'h1_0000_0000) ? '1 : mag * mag;
        acc    = {1'b0, sq_sum} + {1'b0, term};
        sq_sum = acc[64] ? '1 : acc[63:0];
      end
      if (sq_sum < tol) begin
        res.found = 1'b1;
        res.m     = m;
        // plane search: only the upper-left 2x2 block survives
        if (n == 2) begin
          res.m[2] = '0; res.m[5] = '0; res.m[6] = '0; res.m[7] = '0; res.m[8] = '0;
        end
      end
    end
    return res;
  endfunction

  task automatic flag_mismatch(string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatch_total++;
  endtask

  always @(posedge clk) begin : watch
    match_t want;
    if (!rst_n) begin
      dim_reg = DIM_3D;
      tol_reg = RESET_TOL;
      awaited_matches.delete();
    end else begin
      if (in_tvalid && in_tready)
        awaited_matches = {awaited_matches, predict_match(in_tdata, dim_reg, tol_reg)};
      if (out_tvalid && out_tready) begin
        if (awaited_matches.size() == 0) begin
          flag_mismatch("result with no request outstanding");
        end else begin
          want = awaited_matches.pop_front();
          if (out_tuser !== want.found)
            flag_mismatch($sformatf("found got %b want %b", out_tuser, want.found));
          for (int k = 0; k < 9; k++) begin
            if (out_tdata[2*k +: 2] !== want.m[k])
              flag_mismatch($sformatf("m%0d%0d got %0d want %0d", k / 3, k % 3,
                                      ent(out_tdata[2*k +: 2]), ent(want.m[k])));
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == DIM_ADDR) dim_reg = pwdata[1:0];
        else if (paddr == TOL_ADDR) tol_reg = pwdata;
      end
    end
    n_pending  <= awaited_matches.size();
    n_mismatch <= mismatch_total;
  end

endmodule

// ===== tb/tb_signed_permutation_direction_match_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the direction match block: clock, reset, stimulus, flow control and verdict
module tb_signed_permutation_direction_match_top;
  import spdm_pkg::*;

  localparam logic [3:0]  REG_DIMENSION   = 4'h0;
  localparam logic [3:0]  REG_MATCH_TOL   = 4'h8;
  localparam logic [1:0]  DIM_NONE        = 2'd0;
  localparam logic [1:0]  DIM_LINE        = 2'd1;
  localparam logic [63:0] TOL_RESET       = 64'd281;
  localparam logic [63:0] TOL_WIDE        = 64'h0000_0100_0000_0000;
  localparam logic [31:0] Q_ONE           = 32'h0100_0000;
  localparam logic [31:0] MOST_NEG        = 32'h8000_0000;
  localparam logic [31:0] MOST_POS        = 32'h7fff_ffff;
  localparam int          QUIET_LIMIT     = 4000;
  localparam int          HOLD_OFF_CYCLES = 500;
  localparam int          TAIL_CYCLES     = 100;
  localparam int          NOISE_CAP       = 1 << 20;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [191:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [23:0]  out_tdata;
  logic         out_tuser;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [3:0]   paddr;
  logic [63:0]  pwdata;
  logic [63:0]  prdata;
  logic         pready;

  int          n_mismatch;
  int          n_pending;
  int          tx_idle_pct;
  int          rx_stall_pct;
  int          quiet_cycles = 0;
  logic        hold_req;
  logic        hold_done;
  logic [1:0]  cur_dim;
  logic [63:0] cur_tol;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  signed_permutation_direction_match_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  tb_spdm_match_checker #(
    .DIM_ADDR (REG_DIMENSION),
    .TOL_ADDR (REG_MATCH_TOL)
  ) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .n_mismatch (n_mismatch),
    .n_pending  (n_pending)
  );

  // watchdog: cycles with no request, result or register access
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_signed_permutation_direction_match_top: FAIL");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    out_tready = 1'b0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_done <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  function automatic logic [31:0] qv(int units);
    return 32'(units) * Q_ONE;
  endfunction

  function automatic logic [191:0] pack_req(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                                            logic [31:0] tx, logic [31:0] ty, logic [31:0] tz);
    return {tz, ty, tx, sz, sy, sx};
  endfunction

  // component flavours: any bits, small, extremes, small whole numbers
  function automatic logic [31:0] rand_comp(int kind);
    case (kind)
      0: return $urandom;
      1: return 32'($urandom_range(0, 33554432)) - Q_ONE;
      2: begin
        case ($urandom_range(0, 4))
          0: return MOST_NEG;
          1: return MOST_POS;
          2: return 32'd0;
          3: return 32'd1;
          default: return '1;
        endcase
      end
      default: return qv(int'($urandom_range(0, 8)) - 4);
    endcase
  endfunction

  // noise reach around the tolerance radius
  function automatic int noise_limit(logic [63:0] tol);
    logic [63:0] r;
    logic [63:0] trial;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = r | (64'd1 << b);
      if (trial * trial <= tol) r = trial;
    end
    return (r + 2 > NOISE_CAP) ? NOISE_CAP : int'(r) + 2;
  endfunction

  function automatic logic [191:0] random_request();
    logic [31:0] s[3];
    logic [31:0] t[3];
    int          p[3];
    int          mode;
    int          lim;
    longint      val;
    mode = $urandom_range(0, 99);
    for (int i = 0; i < 3; i++) s[i] = rand_comp($urandom_range(0, 3));
    if (mode < 65) begin
      // target is a signed permutation of the source plus a little noise
      if (cur_dim == DIM_2D) begin
        p[0] = $urandom_range(0, 1);
        p[1] = 1 - p[0];
        p[2] = 2;
      end else begin
        p[0] = $urandom_range(0, 2);
        p[1] = (p[0] + 1 + $urandom_range(0, 1)) % 3;
        p[2] = 3 - p[0] - p[1];
      end
      lim = noise_limit(cur_tol);
      for (int i = 0; i < 3; i++) begin
        val = longint'($signed(s[p[i]]));
        if ($urandom_range(0, 1)) val = -val;
        if ($urandom_range(0, 1)) val += longint'($urandom_range(0, 2 * lim)) - lim;
        t[i] = val[31:0];
      end
      if (cur_dim == DIM_2D) t[2] = $urandom;
    end else if (mode < 85) begin
      for (int i = 0; i < 3; i++) t[i] = $urandom;
    end else begin
      for (int i = 0; i < 3; i++) t[i] = rand_comp(2);
    end
    return pack_req(s[0], s[1], s[2], t[0], t[1], t[2]);
  endfunction

  task automatic send_request(input logic [191:0] req);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_tdata  <= req;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(input logic [1:0] dim, input logic [63:0] tol, input int idle,
                           input int stall, input int count, input bit pressure);
    wait_drained();
    tx_idle_pct  = idle;
    rx_stall_pct = stall;
    // junk above the two dimension bits is dropped by the register
    write_reg(REG_DIMENSION, ({$urandom, $urandom} & ~64'h3) | 64'(dim));
    write_reg(REG_MATCH_TOL, tol);
    cur_dim = dim;
    cur_tol = tol;
    send_request('0);
    for (int i = 0; i < count; i++) begin
      if (pressure && i == count / 4) hold_req <= 1'b1;
      if (pressure && i == count / 2) wait_drained();
      send_request(random_request());
    end
  endtask

  // reset register values: 3D search, tolerance 281
  task automatic send_directed();
    send_request(pack_req('0, '0, '0, '0, '0, '0));
    send_request(pack_req(qv(1), qv(2), qv(3), qv(1), qv(2), qv(3)));
    send_request(pack_req(qv(1), qv(2), qv(3), qv(-1), qv(-2), qv(-3)));
    send_request(pack_req(qv(1), qv(2), qv(3), qv(1), qv(-3), qv(2)));
    send_request(pack_req(qv(1), qv(2), qv(3), qv(-3), qv(2), qv(1)));
    send_request(pack_req(qv(1), qv(2), qv(3), qv(-2), qv(1), qv(3)));
    send_request(pack_req(qv(1), qv(2), qv(3), qv(2), qv(3), qv(1)));
    send_request(pack_req(qv(1), qv(2), qv(3), qv(-3), qv(-1), qv(2)));
    send_request(pack_req(qv(1), qv(2), qv(3), qv(1), qv(2), qv(-3)));
    // just inside and just outside the tolerance
    send_request(pack_req(qv(1), qv(2), qv(3), qv(1) + 32'd16, qv(2), qv(3)));
    send_request(pack_req(qv(1), qv(2), qv(3), qv(1) + 32'd17, qv(2), qv(3)));
    send_request(pack_req(qv(1), qv(2), qv(3), qv(1) + 32'd9, qv(2) + 32'd9, qv(3) + 32'd9));
    send_request(pack_req(qv(1), qv(2), qv(3), qv(1) - 32'd10, qv(2) + 32'd10,
                          qv(3) - 32'd10));
    // full-scale components and saturating distances
    send_request(pack_req(MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS, MOST_POS));
    send_request(pack_req(MOST_POS, MOST_POS, MOST_POS, MOST_NEG, MOST_NEG, MOST_NEG));
    send_request(pack_req(MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG));
    send_request(pack_req(MOST_NEG, '0, '0, '0, '0, MOST_NEG));
    send_request(pack_req(MOST_NEG, '0, '0, MOST_NEG, MOST_NEG, MOST_NEG));
    send_request(pack_req(MOST_NEG, MOST_POS, 32'd1, MOST_POS, MOST_NEG, '1));
    send_request(pack_req('1, '1, '1, '1, '1, '1));
    send_request(random_request());
    send_request(random_request());
  endtask

  initial begin : stimulus
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_req     = 1'b0;
    cur_dim      = DIM_3D;
    cur_tol      = TOL_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_directed();
    run_phase(DIM_3D, TOL_RESET, 0, 0, 300, 1'b0);
    run_phase(DIM_2D, TOL_RESET, 55, 0, 250, 1'b0);
    run_phase(DIM_3D, TOL_WIDE, 0, 55, 250, 1'b0);
    run_phase(DIM_2D, '1, 14, 14, 100, 1'b0);
    run_phase(DIM_3D, 64'd1, 14, 14, 200, 1'b0);
    run_phase(DIM_3D, '0, 0, 0, 40, 1'b0);
    run_phase(DIM_LINE, TOL_RESET, 55, 55, 40, 1'b0);
    run_phase(DIM_NONE, TOL_RESET, 0, 0, 40, 1'b0);
    run_phase(DIM_2D, 64'd1 << $urandom_range(20, 50), 0, 0, 150, 1'b0);
    run_phase(DIM_3D, TOL_RESET, 14, 14, 300, 1'b1);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_mismatch == 0 && n_pending == 0)
      $display("tb_signed_permutation_direction_match_top: PASS");
    else
      $display("tb_signed_permutation_direction_match_top: FAIL");
    $finish;
  end

endmodule
